/* design/imufd_pkg.sv */
// Shared types, frame constants and the axis scaling function of the IMU frame decoder.
package imufd_pkg;

	// Result kinds as presented on the kind port
	typedef enum logic [1:0] {
		KIND_ANGLE = 2'd0,
		KIND_MAG   = 2'd1,
		KIND_ACCEL = 2'd2,
		KIND_RATE  = 2'd3
	} kind_t;

	// Header and frame type bytes
	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_MAG   = 8'h54;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;

	// Byte offsets inside a frame
	localparam int POS_HEADER = 0;
	localparam int POS_TYPE   = 1;
	localparam int POS_X_LO   = 2;
	localparam int POS_X_HI   = 3;
	localparam int POS_Y_LO   = 4;
	localparam int POS_Y_HI   = 5;
	localparam int POS_Z_LO   = 6;
	localparam int POS_Z_HI   = 7;

	// Scale factors in units of 2^-16 per count (180/32768, 2/32768, 2000/32768)
	localparam int FACT_W = 13;
	localparam logic signed [FACT_W-1:0] SCALE_ANGLE = 13'sd360;
	localparam logic signed [FACT_W-1:0] SCALE_MAG   = 13'sd1;
	localparam logic signed [FACT_W-1:0] SCALE_ACCEL = 13'sd4;
	localparam logic signed [FACT_W-1:0] SCALE_RATE  = 13'sd4000;

	localparam int AXIS_W = 28;

	// Result kind plus the three raw sensor words of one frame, handed to the scaling stage
	typedef struct packed {
		kind_t       kind;
		logic [15:0] wx;
		logic [15:0] wy;
		logic [15:0] wz;
	} frame_words_t;

	// One constant multiply: word (signed or unsigned) times a signed factor
	function automatic logic signed [AXIS_W-1:0] scale_word(
		input logic [15:0]                w,
		input logic                       is_signed,
		input logic signed [FACT_W-1:0]   fact
	);
		logic signed [16:0] op;
		logic signed [29:0] prod;
		op   = is_signed ? {w[15], w} : {1'b0, w};
		prod = 30'(op) * 30'(fact);
		return prod[AXIS_W-1:0];
	endfunction

endpackage

/* design/imu_frame_decoder.sv */
// IMU serial frame decoder: byte tracking, frame capture and axis scaling pipeline.
// Data byte 7 sends a result through the word stage and then the result register.
// Throughput: one byte per cycle; the byte tracker, a word register stage and the
// result register each take a new entry every cycle the downstream side can move.
// Reset (arst_n low) clears frame position, frame count, held bytes and both valid flags.
// Without a buffer_start after reset, bytes are counted as if a buffer had just begun.
module imu_frame_decoder #(
	parameter int FRAME_BYTES = 11,
	parameter int FRAMES      = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         buffer_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   kind,
	output logic signed [imufd_pkg::AXIS_W-1:0] axis_x,
	output logic signed [imufd_pkg::AXIS_W-1:0] axis_y,
	output logic signed [imufd_pkg::AXIS_W-1:0] axis_z
);
	import imufd_pkg::*;

	localparam int POS_W  = $clog2(FRAME_BYTES);
	localparam int FIDX_W = $clog2(FRAMES + 1);

	// Frame tracking state
	logic [POS_W-1:0]  pos_q;
	logic [FIDX_W-1:0] fidx_q;
	logic              hdr_ok_q;
	logic [7:0]        ftype_q;
	logic [7:0]        lo_q;
	logic [15:0]       wx_q;
	logic [15:0]       wy_q;

	// Pipeline registers
	logic         s1_valid_q;
	frame_words_t s1_words_q;
	logic         out_valid_q;
	kind_t        kind_q;
	logic signed [AXIS_W-1:0] ax_q, ay_q, az_q;

	// Handshake and decode signals
	logic              in_acc;
	logic              out_load;
	logic [POS_W-1:0]  pos_eff;
	logic [FIDX_W-1:0] fidx_eff;
	logic              active;
	logic              emit;
	kind_t             kind_dec;
	logic              last_byte;

	// Backpressure: output register frees when empty or taken, word stage follows it
	assign out_load = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || out_load;
	assign in_acc   = in_valid && in_ready;

	// Position after a possible buffer restart
	assign pos_eff   = buffer_start ? '0 : pos_q;
	assign fidx_eff  = buffer_start ? '0 : fidx_q;
	assign active    = fidx_eff < FIDX_W'(FRAMES);
	assign last_byte = pos_eff >= POS_W'(FRAME_BYTES - 1);

	// Type decode for the last data byte
	always_comb begin
		emit     = 1'b0;
		kind_dec = KIND_ANGLE;
		if (active && pos_eff == POS_W'(POS_Z_HI) && hdr_ok_q) begin
			case (ftype_q)
				TYPE_ANGLE: begin emit = 1'b1; kind_dec = KIND_ANGLE; end
				TYPE_MAG:   begin emit = 1'b1; kind_dec = KIND_MAG;   end
				TYPE_ACCEL: begin emit = 1'b1; kind_dec = KIND_ACCEL; end
				TYPE_RATE:  begin emit = 1'b1; kind_dec = KIND_RATE;  end
				default:    begin emit = 1'b0; kind_dec = KIND_ANGLE; end
			endcase
		end
	end

	// Frame tracker: header, type and word capture per byte offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fidx_q   <= '0;
			hdr_ok_q <= 1'b0;
			ftype_q  <= '0;
			lo_q     <= '0;
			wx_q     <= '0;
			wy_q     <= '0;
		end else if (in_acc && active) begin
			if (pos_eff == POS_W'(POS_HEADER)) begin
				hdr_ok_q <= (data_byte == HDR_BYTE);
			end
			if (pos_eff == POS_W'(POS_TYPE)) begin
				ftype_q <= data_byte;
			end
			if (pos_eff == POS_W'(POS_X_LO) || pos_eff == POS_W'(POS_Y_LO) ||
			    pos_eff == POS_W'(POS_Z_LO)) begin
				lo_q <= data_byte;
			end
			if (pos_eff == POS_W'(POS_X_HI)) begin
				wx_q <= {data_byte, lo_q};
			end
			if (pos_eff == POS_W'(POS_Y_HI)) begin
				wy_q <= {data_byte, lo_q};
			end
			if (last_byte) begin
				pos_q  <= '0;
				fidx_q <= fidx_eff + FIDX_W'(1);
			end else begin
				pos_q  <= pos_eff + POS_W'(1);
				fidx_q <= fidx_eff;
			end
		end
	end

	// Word stage: one frame's raw words, held until the result register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_acc && emit) begin
			s1_words_q.kind <= kind_dec;
			s1_words_q.wx   <= wx_q;
			s1_words_q.wy   <= wy_q;
			s1_words_q.wz   <= {data_byte, lo_q};
		end
	end

	// Scaling: one constant multiply per axis, x inversion for angle and rate folded into the factor
	logic                     x_sgn, yz_sgn;
	logic signed [FACT_W-1:0] x_fact, yz_fact;

	always_comb begin
		case (s1_words_q.kind)
			KIND_ANGLE: begin x_sgn = 1'b1; yz_sgn = 1'b0; x_fact = -SCALE_ANGLE;
				yz_fact = SCALE_ANGLE; end
			KIND_MAG: begin x_sgn = 1'b0; yz_sgn = 1'b0; x_fact = SCALE_MAG;
				yz_fact = SCALE_MAG; end
			KIND_ACCEL: begin x_sgn = 1'b0; yz_sgn = 1'b0; x_fact = SCALE_ACCEL;
				yz_fact = SCALE_ACCEL; end
			KIND_RATE: begin x_sgn = 1'b1; yz_sgn = 1'b1; x_fact = -SCALE_RATE;
				yz_fact = SCALE_RATE; end
			default: begin x_sgn = 1'b0; yz_sgn = 1'b0; x_fact = SCALE_MAG;
				yz_fact = SCALE_MAG; end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && s1_valid_q) begin
			kind_q <= s1_words_q.kind;
			ax_q   <= scale_word(s1_words_q.wx, x_sgn, x_fact);
			ay_q   <= scale_word(s1_words_q.wy, yz_sgn, yz_fact);
			az_q   <= scale_word(s1_words_q.wz, yz_sgn, yz_fact);
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign axis_x    = ax_q;
	assign axis_y    = ay_q;
	assign axis_z    = az_q;

	// Checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < FRAME_BYTES)
		else $error("frame position beyond frame length");

	a_fidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fidx_q) <= FRAMES)
		else $error("frame count beyond limit");

	a_emit_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && emit |=> s1_valid_q)
		else $error("decoded frame not captured in word stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_words_q))
		else $error("word stage lost or changed a stalled frame");

	a_mag_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_MAG |->
		ax_q[AXIS_W-1:16] == '0 && ay_q[AXIS_W-1:16] == '0 && az_q[AXIS_W-1:16] == '0)
		else $error("magnetometer counts not passed raw");

endmodule
